// ----- design/far_pkg.sv -----
// Package for the fraction arithmetic and reduction block: widths, commands, states, control and status structs.
`timescale 1ns / 1ps
package far_pkg;
    localparam int OPERAND_BITS = 16;
    localparam int PROD_BITS    = 2 * OPERAND_BITS;
    localparam int MAG_BITS     = PROD_BITS + 1;
    localparam int NUM_BITS     = 33;
    localparam int DEN_BITS     = 32;
    localparam int CNT_BITS     = $clog2(MAG_BITS + 1);
    localparam int IN_BITS      = 2 + 4 * OPERAND_BITS;
    localparam int IN_BYTES     = (IN_BITS + 7) / 8;
    localparam int OUT_BITS     = NUM_BITS + DEN_BITS + 1;
    localparam int OUT_BYTES    = (OUT_BITS + 7) / 8;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_SUM,
        ST_GCD_INIT,
        ST_GCD_DIV,
        ST_GCD_STEP,
        ST_QN_INIT,
        ST_QN_DIV,
        ST_QD_INIT,
        ST_QD_DIV,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic sum;
        logic gcd_init;
        logic div_step;
        logic gcd_step;
        logic qn_init;
        logic qd_init;
        logic out_load;
    } t_ctrl;

    // datapath -> controller
    typedef struct packed {
        logic both_zero;
        logic div_done;
        logic rem_zero;
    } t_stat;
endpackage

// ----- design/far_ctrl.sv -----
// Controller FSM sequencing products, Euclid steps and the two quotient divisions.
`timescale 1ns / 1ps
module far_ctrl
    import far_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_fire,
    input  logic   i_out_busy,
    input  t_stat  i_stat,
    output logic   o_in_ready,
    output t_ctrl  o_ctrl
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (i_in_fire) n_state = ST_MUL1;
            ST_MUL1:     n_state = ST_MUL2;
            ST_MUL2:     n_state = ST_SUM;
            ST_SUM:      n_state = ST_GCD_INIT;
            ST_GCD_INIT: n_state = i_stat.both_zero ? ST_OUT : ST_GCD_STEP;
            ST_GCD_STEP: n_state = i_stat.rem_zero ? ST_QN_INIT : ST_GCD_DIV;
            ST_GCD_DIV:  if (i_stat.div_done) n_state = ST_GCD_STEP;
            ST_QN_INIT:  n_state = ST_QN_DIV;
            ST_QN_DIV:   if (i_stat.div_done) n_state = ST_QD_INIT;
            ST_QD_INIT:  n_state = ST_QD_DIV;
            ST_QD_DIV:   if (i_stat.div_done) n_state = ST_OUT;
            ST_OUT:      if (!i_out_busy) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_ctrl.load = i_in_fire;
            end
            ST_MUL1:     o_ctrl.mul1 = 1'b1;
            ST_MUL2:     o_ctrl.mul2 = 1'b1;
            ST_SUM:      o_ctrl.sum = 1'b1;
            ST_GCD_INIT: o_ctrl.gcd_init = 1'b1;
            ST_GCD_STEP: o_ctrl.gcd_step = 1'b1;
            ST_GCD_DIV,
            ST_QN_DIV,
            ST_QD_DIV:   o_ctrl.div_step = 1'b1;
            ST_QN_INIT:  o_ctrl.qn_init = 1'b1;
            ST_QD_INIT:  o_ctrl.qd_init = 1'b1;
            ST_OUT:      o_ctrl.out_load = !i_out_busy;
            default:     o_ctrl = '0;
        endcase
    end
endmodule

// ----- design/far_dp.sv -----
// Datapath: sign-magnitude products, Euclid remainder loop and restoring divider.
`timescale 1ns / 1ps
module far_dp
    import far_pkg::*;
(
    input  logic                 i_clk,
    input  t_ctrl                i_ctrl,
    input  logic [1:0]           i_command,
    input  logic [OPERAND_BITS-1:0] i_a_num,
    input  logic [OPERAND_BITS-1:0] i_a_den,
    input  logic [OPERAND_BITS-1:0] i_b_num,
    input  logic [OPERAND_BITS-1:0] i_b_den,
    output t_stat                o_stat,
    output logic [NUM_BITS-1:0]  o_result_num,
    output logic [DEN_BITS-1:0]  o_result_den,
    output logic                 o_undefined
);
    localparam logic [CNT_BITS-1:0] LastBit = CNT_BITS'(MAG_BITS - 1);

    t_cmd r_cmd;
    logic [OPERAND_BITS-1:0] r_mag [4];
    logic [3:0]              r_neg;
    logic [PROD_BITS-1:0]    r_p1, r_p2;
    logic                    r_p1_neg, r_p2_neg;
    logic [MAG_BITS-1:0]     r_rn, r_rd;
    logic                    r_rn_neg, r_rd_neg;
    logic [MAG_BITS-1:0]     r_x, r_y;
    logic                    r_k;
    // divider
    logic [MAG_BITS-1:0]     r_dvd, r_rem, r_dvs;
    logic [CNT_BITS-1:0]     r_cnt;
    logic                    r_busy;
    logic [MAG_BITS-1:0]     r_qn;
    logic                    r_g_neg;

    logic [OPERAND_BITS-1:0] raw [4];
    logic [MAG_BITS:0]       trial;
    logic [MAG_BITS-1:0]     shifted;

    assign raw[0] = i_a_num;
    assign raw[1] = i_a_den;
    assign raw[2] = i_b_num;
    assign raw[3] = i_b_den;

    assign shifted = {r_rem[MAG_BITS-2:0], r_dvd[MAG_BITS-1]};
    assign trial   = {1'b0, shifted} - {1'b0, r_dvs};

    assign o_stat.both_zero = (r_rn == '0) && (r_rd == '0);
    assign o_stat.div_done  = r_busy && (r_cnt == '0);
    assign o_stat.rem_zero  = (r_y == '0);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= t_cmd'(i_command);
            for (int i = 0; i < 4; i++) begin
                r_neg[i] <= raw[i][OPERAND_BITS-1];
                r_mag[i] <= raw[i][OPERAND_BITS-1] ? (~raw[i] + 1'b1) : raw[i];
            end
        end
        // mag of most negative wraps to itself, which is the right unsigned value
        if (i_ctrl.mul1) begin
            unique case (r_cmd)
                CMD_MUL: begin
                    r_p1 <= r_mag[0] * r_mag[2];
                    r_p1_neg <= r_neg[0] ^ r_neg[2];
                end
                default: begin
                    r_p1 <= r_mag[0] * r_mag[3];
                    r_p1_neg <= r_neg[0] ^ r_neg[3];
                end
            endcase
            unique case (r_cmd)
                CMD_DIV: begin
                    r_p2 <= r_mag[1] * r_mag[2];
                    r_p2_neg <= r_neg[1] ^ r_neg[2];
                end
                default: begin
                    r_p2 <= r_mag[1] * r_mag[3];
                    r_p2_neg <= r_neg[1] ^ r_neg[3];
                end
            endcase
        end
        if (i_ctrl.mul2) begin
            // denominator ready; third product (b_num*a_den) reuses r_p2 slot after
            r_rd     <= {1'b0, r_p2};
            r_rd_neg <= (r_p2 != '0) && r_p2_neg;
            r_rn     <= {1'b0, r_p1};
            r_rn_neg <= (r_p1 != '0) && r_p1_neg;
            r_p2     <= r_mag[2] * r_mag[1];
            r_p2_neg <= (r_neg[2] ^ r_neg[1]) ^ (r_cmd == CMD_SUB);
        end
        if (i_ctrl.sum && (r_cmd == CMD_ADD || r_cmd == CMD_SUB) && r_p2 != '0) begin
            if (r_rn_neg == r_p2_neg) begin
                r_rn     <= r_rn + {1'b0, r_p2};
                r_rn_neg <= r_p2_neg;
            end else if (r_rn >= {1'b0, r_p2}) begin
                r_rn     <= r_rn - {1'b0, r_p2};
                r_rn_neg <= (r_rn != {1'b0, r_p2}) && r_rn_neg;
            end else begin
                r_rn     <= {1'b0, r_p2} - r_rn;
                r_rn_neg <= r_p2_neg;
            end
        end
        if (i_ctrl.gcd_init) begin
            r_x <= r_rn;
            r_y <= r_rd;
            r_k <= 1'b0;
        end
        r_busy <= 1'b0;
        if (i_ctrl.gcd_step && r_y != '0) begin
            r_x    <= r_y;
            r_k    <= ~r_k;
            r_dvd  <= r_x;
            r_dvs  <= r_y;
            r_rem  <= '0;
            r_cnt  <= LastBit;
            r_busy <= 1'b1;
        end
        if (i_ctrl.gcd_step && r_y == '0) begin
            r_g_neg <= r_k ? r_rd_neg : r_rn_neg;
        end
        // numerator quotient is complete when the denominator division starts
        if (i_ctrl.qd_init) begin
            r_qn <= r_dvd;
        end
        if (i_ctrl.qn_init || i_ctrl.qd_init) begin
            r_dvd  <= i_ctrl.qn_init ? r_rn : r_rd;
            r_dvs  <= r_x;
            r_rem  <= '0;
            r_cnt  <= LastBit;
            r_busy <= 1'b1;
        end
        if (i_ctrl.div_step && r_busy) begin
            if (!trial[MAG_BITS]) begin
                r_rem <= trial[MAG_BITS-1:0];
            end else begin
                r_rem <= shifted;
            end
            r_dvd <= {r_dvd[MAG_BITS-2:0], !trial[MAG_BITS]};
            r_cnt <= r_cnt - 1'b1;
            r_busy <= (r_cnt != '0);
            if (r_cnt == '0) begin
                // remainder feeds the next Euclid term
                r_y <= trial[MAG_BITS] ? shifted : trial[MAG_BITS-1:0];
            end
        end
        if (i_ctrl.out_load) begin
            if (o_stat.both_zero) begin
                o_result_num <= '0;
                o_result_den <= '0;
                o_undefined  <= 1'b1;
            end else begin
                o_result_num <= (r_qn != '0 && (r_rn_neg ^ r_g_neg))
                    ? NUM_BITS'(-r_qn) : NUM_BITS'(r_qn);
                o_result_den <= (r_dvd != '0 && (r_rd_neg ^ r_g_neg))
                    ? DEN_BITS'(-r_dvd) : DEN_BITS'(r_dvd);
                o_undefined  <= 1'b0;
            end
        end
    end
endmodule

// ----- design/fraction_arith_reduce.sv -----
// Top level of the fraction arithmetic and reduction block.
// Usage:
//  Slave channel carries one beat per operation: command, a_num, a_den, b_num, b_den.
//  Master channel returns one beat per operation: result_num, result_den, undefined.
//  The raw numerator and denominator are formed exactly by two 16x16 multipliers
//  in the MUL1 and MUL2 states plus, for add and subtract, a sum in the SUM state,
//  then reduced by the gcd from Euclid's remainder sequence. Every remainder and
//  both final quotients come from one restoring divider that retires one bit per
//  cycle over 33 bits, each division after a setup state. Euclid steps range
//  0..~46. When both raw values are zero the raw zeros are returned with undefined
//  set.
//  One item is in flight at a time; s_axis_tready is high only when idle, so a
//  new beat can be taken in the cycle after the previous result is loaded.
//  Results sit in an output register until the receiver takes them; an item
//  accepted meanwhile is computed and then waits for that register to free up.
//  Synchronous active-low reset returns the controller to idle and empties the
//  output register.
`timescale 1ns / 1ps
module fraction_arith_reduce
    import far_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // command[1:0], a_num, a_den, b_num, b_den, zero pad
    input  logic [IN_BYTES*8-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // result_num[32:0], result_den[64:33], undefined[65], zero pad
    output logic [OUT_BYTES*8-1:0] m_axis_tdata
);
    t_ctrl ctrl;
    t_stat stat;
    logic  in_fire;
    logic  r_out_valid;
    logic [NUM_BITS-1:0] res_num;
    logic [DEN_BITS-1:0] res_den;
    logic                res_undef;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    far_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_out_busy (r_out_valid && !m_axis_tready),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_ctrl     (ctrl)
    );

    far_dp u_dp (
        .i_clk        (i_clk),
        .i_ctrl       (ctrl),
        .i_command    (s_axis_tdata[1:0]),
        .i_a_num      (s_axis_tdata[2+OPERAND_BITS-1:2]),
        .i_a_den      (s_axis_tdata[2+2*OPERAND_BITS-1:2+OPERAND_BITS]),
        .i_b_num      (s_axis_tdata[2+3*OPERAND_BITS-1:2+2*OPERAND_BITS]),
        .i_b_den      (s_axis_tdata[2+4*OPERAND_BITS-1:2+3*OPERAND_BITS]),
        .o_stat       (stat),
        .o_result_num (res_num),
        .o_result_den (res_den),
        .o_undefined  (res_undef)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_BYTES*8-OUT_BITS){1'b0}}, res_undef, res_den, res_num};
endmodule

// ----- design/far_checker.sv -----
// Port-level checker for the fraction arithmetic block, bound to the top level.
`timescale 1ns / 1ps
module far_checker
    import far_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [OUT_BYTES*8-1:0] m_axis_tdata
);
    // a result never shows up right after acceptance (multiply and reduce take cycles)
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result too early");

    // one item at a time: input closes right after an accepted beat
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted while busy");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled beat changed");

    // undefined results carry zero numerator and denominator
    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[NUM_BITS+DEN_BITS] |->
        m_axis_tdata[NUM_BITS+DEN_BITS-1:0] == '0)
        else $error("undefined with nonzero values");
endmodule

bind fraction_arith_reduce far_checker u_far_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
